// ===== hw/rtl/go_back_n_receiver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Go-back-N receiver assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_RECEIVER_CORE_MACROS_SVH
`define GO_BACK_N_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and types of the go-back-N receiver datagram checker.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int MAX_PAYLOAD  = 1023;
	localparam int COUNT_CAP    = 2047;
	// bytes past this count are dropped and flag an overrun
	localparam int COUNT_LIMIT  = (HEADER_BYTES + MAX_PAYLOAD < COUNT_CAP) ?
		(HEADER_BYTES + MAX_PAYLOAD) : COUNT_CAP;

	localparam int CNT_W = 11;
	localparam int LEN_W = 16;
	localparam int OUT_LEN_W = 10;

	// header byte positions
	localparam int SEQ_BYTES    = 4;
	localparam int IDX_CKSUM_HI = 12;
	localparam int IDX_CKSUM_LO = 13;
	localparam int IDX_LEN_LO   = 14;
	localparam int IDX_LEN_HI   = 15;

	localparam logic [15:0] CKSUM_OK = 16'hFFFF;

	// datagram totals after its final byte
	typedef struct packed {
		logic [31:0]      sum;
		logic [31:0]      seq;
		logic [15:0]      cksum;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] count;
		logic             overrun;
	} snap_t;

endpackage

// ===== hw/rtl/gbn_rx_if.sv =====
// ----------------------------------------------------------------------------
// gbn_rx_if
// Byte request channel: one datagram byte with its end flag.
// ----------------------------------------------------------------------------
interface gbn_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/gbn_status_if.sv =====
// ----------------------------------------------------------------------------
// gbn_status_if
// Result request channel: verdict and ack fields for one datagram.
// ----------------------------------------------------------------------------
interface gbn_status_if;
	logic        valid;
	logic        ready;
	logic        packet_good;
	logic        deliver;
	logic        send_ack;
	logic [31:0] ack_number;
	logic [15:0] ack_checksum;
	logic [9:0]  payload_length;

	modport source (output valid, output packet_good, output deliver, output send_ack,
		output ack_number, output ack_checksum, output payload_length, input ready);
	modport sink (input valid, input packet_good, input deliver, input send_ack,
		input ack_number, input ack_checksum, input payload_length, output ready);
endinterface

// ===== hw/rtl/gbn_accum.sv =====
// ----------------------------------------------------------------------------
// gbn_accum
// Input register and per-datagram accumulator; snapshots totals on last byte.
// ----------------------------------------------------------------------------
`include "go_back_n_receiver_core_macros.svh"

module gbn_accum (
	input  logic          clk,
	input  logic          arst_n,
	gbn_rx_if.sink        rx,
	output logic          snap_valid,
	output gbn_pkg::snap_t snap,
	input  logic          snap_ready
);

	logic                      valid_s1;
	logic [7:0]                data_s1;
	logic                      last_s1;
	logic                      consume;

	logic [gbn_pkg::CNT_W-1:0] count_q, count_n;
	logic [31:0]               sum_q, sum_n;
	logic [31:0]               seq_q, seq_n;
	logic [15:0]               cksum_q, cksum_n;
	logic [gbn_pkg::LEN_W-1:0] len_q, len_n;
	logic [7:0]                held_q, held_n;
	logic                      overrun_q, overrun_n;
	logic [gbn_pkg::CNT_W-1:0] pidx;
	logic [3:0]                hidx;
	logic                      full;

	// a last byte waits until the snapshot slot is free
	assign consume  = valid_s1 && (!last_s1 || !snap_valid || snap_ready);
	assign rx.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			data_s1 <= rx.data_byte;
			last_s1 <= rx.last_byte;
		end
	end

	always_comb begin
		count_n   = count_q;
		sum_n     = sum_q;
		seq_n     = seq_q;
		cksum_n   = cksum_q;
		len_n     = len_q;
		held_n    = held_q;
		overrun_n = overrun_q;
		hidx      = count_q[3:0];
		pidx      = count_q - gbn_pkg::CNT_W'(gbn_pkg::HEADER_BYTES);
		full      = overrun_q || (count_q >= gbn_pkg::CNT_W'(gbn_pkg::COUNT_LIMIT));
		if (full) begin
			overrun_n = 1'b1;
		end else begin
			count_n = count_q + 1'b1;
			if (count_q < gbn_pkg::CNT_W'(gbn_pkg::HEADER_BYTES)) begin
				if (count_q < gbn_pkg::CNT_W'(gbn_pkg::SEQ_BYTES)) begin
					seq_n = {seq_q[23:0], data_s1};
				end
				if (hidx == 4'(gbn_pkg::IDX_LEN_LO)) begin
					len_n[7:0] = data_s1;
				end
				if (hidx == 4'(gbn_pkg::IDX_LEN_HI)) begin
					len_n[15:8] = data_s1;
				end
				// checksum word stays out of the sum
				if (hidx == 4'(gbn_pkg::IDX_CKSUM_HI)) begin
					cksum_n = {data_s1, 8'h00};
				end else if (hidx == 4'(gbn_pkg::IDX_CKSUM_LO)) begin
					cksum_n[7:0] = data_s1;
				end else if (!hidx[0]) begin
					held_n = data_s1;
				end else begin
					sum_n = sum_q + {16'h0000, held_q, data_s1};
				end
			end else if ({5'b00000, pidx} < len_q) begin
				if (!pidx[0]) begin
					// odd final payload byte goes in unshifted
					if ({5'b00000, pidx} + 16'd1 == len_q) begin
						sum_n = sum_q + {24'h000000, data_s1};
					end else begin
						held_n = data_s1;
					end
				end else begin
					sum_n = sum_q + {16'h0000, held_q, data_s1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_q     <= '0;
			seq_q     <= '0;
			cksum_q   <= '0;
			len_q     <= '0;
			held_q    <= '0;
			overrun_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				count_q   <= '0;
				sum_q     <= '0;
				seq_q     <= '0;
				cksum_q   <= '0;
				len_q     <= '0;
				held_q    <= '0;
				overrun_q <= 1'b0;
			end else begin
				count_q   <= count_n;
				sum_q     <= sum_n;
				seq_q     <= seq_n;
				cksum_q   <= cksum_n;
				len_q     <= len_n;
				held_q    <= held_n;
				overrun_q <= overrun_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid <= 1'b0;
		end else if (consume && last_s1) begin
			snap_valid <= 1'b1;
		end else if (snap_ready) begin
			snap_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			snap.sum     <= sum_n;
			snap.seq     <= seq_n;
			snap.cksum   <= cksum_n;
			snap.len     <= len_n;
			snap.count   <= count_n;
			snap.overrun <= overrun_n;
		end
	end

	`GBN_ASSERT_IMPL(a_overrun_at_limit, overrun_q, count_q == gbn_pkg::CNT_W'(gbn_pkg::COUNT_LIMIT), "overrun without full count")
	`GBN_ASSERT_NEXT(a_clear_after_last, consume && last_s1, count_q == '0 && !overrun_q, "datagram state not cleared")
	`GBN_ASSERT_NEXT(a_snap_hold, snap_valid && !snap_ready, snap_valid && $stable(snap), "snapshot lost while stalled")

endmodule

// ===== hw/rtl/gbn_verdict.sv =====
// ----------------------------------------------------------------------------
// gbn_verdict
// Checksum and length verdict, sequence tracking and the result register.
// ----------------------------------------------------------------------------
`include "go_back_n_receiver_core_macros.svh"

module gbn_verdict (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           snap_valid,
	input  gbn_pkg::snap_t snap,
	output logic           snap_ready,
	gbn_status_if.source   status
);

	logic        out_valid_q;
	logic        good_q;
	logic        deliver_q;
	logic        ack_q;
	logic [31:0] ack_number_q;
	logic [15:0] ack_cksum_q;
	logic [9:0]  length_q;
	logic [31:0] expected_q;

	logic [15:0] fold;
	logic [16:0] need;
	logic        good_c;
	logic [31:0] seq_c;
	logic        del_c;
	logic        ack_c;
	logic [16:0] half_sum;
	logic [8:0]  ack_fold;
	logic        take;

	assign snap_ready = !out_valid_q || status.ready;
	assign take       = snap_valid && snap_ready;

	always_comb begin
		fold   = 16'({8'h00, snap.sum[7:0]} + {8'h00, snap.sum[23:16]} + snap.cksum);
		need   = 17'(gbn_pkg::HEADER_BYTES) + {1'b0, snap.len};
		good_c = !snap.overrun
			&& ({6'b000000, snap.count} >= need)
			&& (snap.len <= gbn_pkg::LEN_W'(gbn_pkg::MAX_PAYLOAD))
			&& (fold == gbn_pkg::CKSUM_OK);
		// header carries the sequence least significant byte first
		seq_c    = {snap.seq[7:0], snap.seq[15:8], snap.seq[23:16], snap.seq[31:24]};
		del_c    = good_c && (seq_c == expected_q);
		ack_c    = good_c && (seq_c <= expected_q);
		half_sum = {1'b0, snap.seq[31:16]} + {1'b0, snap.seq[15:0]};
		ack_fold = {1'b0, half_sum[7:0]} + {8'h00, half_sum[16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			expected_q  <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (status.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && del_c) begin
				expected_q <= expected_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			good_q       <= good_c;
			deliver_q    <= del_c;
			ack_q        <= ack_c;
			ack_number_q <= snap.seq;
			ack_cksum_q  <= ~{7'b0000000, ack_fold};
			length_q     <= snap.len[gbn_pkg::OUT_LEN_W-1:0];
		end
	end

	assign status.valid          = out_valid_q;
	assign status.packet_good    = good_q;
	assign status.deliver        = deliver_q;
	assign status.send_ack       = ack_q;
	assign status.ack_number     = ack_number_q;
	assign status.ack_checksum   = ack_cksum_q;
	assign status.payload_length = length_q;

	`GBN_ASSERT_IMPL(a_deliver_implies_ack, out_valid_q && deliver_q, ack_q && good_q, "deliver without ack")
	`GBN_ASSERT_IMPL(a_ack_implies_good, out_valid_q && ack_q, good_q, "ack on bad packet")
	`GBN_ASSERT_NEXT(a_expected_advance, take && del_c, expected_q == $past(expected_q) + 32'd1, "expected sequence did not advance")

endmodule

// ===== hw/rtl/go_back_n_receiver_core.sv =====
// ----------------------------------------------------------------------------
// go_back_n_receiver_core
// Go-back-N receiver datagram checker: sums header and payload, verifies
// checksum and length, tracks the expected sequence and decides deliver/ack.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                    Per request
// rx       in   data_byte[7:0], last_byte                  one datagram byte
// status   out  packet_good, deliver, send_ack,            one per last byte
//               ack_number[31:0], ack_checksum[15:0],
//               payload_length[9:0]
//
// One byte per cycle sustained while no last byte waits for the snapshot slot;
// a byte passes the input register, the accumulator and, if last, the
// snapshot and result registers. Reset clears all datagram state and the
// expected sequence. A stalled status channel holds the result; bytes keep
// flowing until a second last byte finds the snapshot slot still occupied.
// ----------------------------------------------------------------------------
module go_back_n_receiver_core (
	input  logic         clk,
	input  logic         arst_n,
	gbn_rx_if.sink       rx,
	gbn_status_if.source status
);

	logic           snap_valid;
	logic           snap_ready;
	gbn_pkg::snap_t snap;

	gbn_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready)
	);

	gbn_verdict u_verdict (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready),
		.status     (status)
	);

endmodule

// ===== sim/datagram_verdict_monitor.sv =====
// ----------------------------------------------------------------------------
// datagram_verdict_monitor
// Watches the byte and status channels, rebuilds each datagram's verdict from
// the accepted bytes and compares it field by field with the status request.
// ----------------------------------------------------------------------------
module datagram_verdict_monitor (
	input  logic  clk,
	input  logic  arst_n,
	gbn_rx_if     rx,
	gbn_status_if status,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic        good;
		logic        deliver;
		logic        ack;
		logic [31:0] ack_num;
		logic [15:0] ack_ck;
		logic [9:0]  len;
	} verdict_t;

	verdict_t verdicts_due[$];

	// running datagram state
	logic [gbn_pkg::CNT_W-1:0] byte_cnt;
	logic [31:0]               run_sum;
	logic [31:0]               seq_bytes;
	logic [15:0]               rx_cksum;
	logic [gbn_pkg::LEN_W-1:0] len_field;
	logic [7:0]                held;
	logic                      overrun;
	logic [31:0]               next_seq;

	function automatic void clear_datagram();
		byte_cnt  = '0;
		run_sum   = '0;
		seq_bytes = '0;
		rx_cksum  = '0;
		len_field = '0;
		held      = '0;
		overrun   = 1'b0;
	endfunction

	function automatic void absorb(input logic [gbn_pkg::CNT_W-1:0] idx, input logic [7:0] b);
		logic [gbn_pkg::CNT_W-1:0] p;
		if (idx < gbn_pkg::HEADER_BYTES) begin
			if (idx < gbn_pkg::SEQ_BYTES)
				seq_bytes = {seq_bytes[23:0], b};
			if (idx == gbn_pkg::IDX_LEN_LO)
				len_field[7:0] = b;
			if (idx == gbn_pkg::IDX_LEN_HI)
				len_field[15:8] = b;
			if (idx == gbn_pkg::IDX_CKSUM_HI)
				rx_cksum = {b, 8'h00};
			else if (idx == gbn_pkg::IDX_CKSUM_LO)
				rx_cksum[7:0] = b;
			else if (!idx[0])
				held = b;
			else
				run_sum += {16'h0000, held, b};
		end else begin
			p = idx - gbn_pkg::CNT_W'(gbn_pkg::HEADER_BYTES);
			// bytes past the declared length are counted, not summed
			if ({5'b00000, p} < len_field) begin
				if (!p[0]) begin
					if ({5'b00000, p} + 16'd1 == len_field)
						run_sum += {24'h000000, b};
					else
						held = b;
				end else begin
					run_sum += {16'h0000, held, b};
				end
			end
		end
	endfunction

	function automatic void take_byte(input logic [7:0] b, input logic fin);
		verdict_t    v;
		logic [15:0] fold;
		logic [31:0] seq;
		logic [16:0] halves;
		logic [15:0] ack_fold;
		if (overrun || byte_cnt >= gbn_pkg::HEADER_BYTES + gbn_pkg::MAX_PAYLOAD ||
			byte_cnt >= gbn_pkg::COUNT_CAP) begin
			overrun = 1'b1;
		end else begin
			absorb(byte_cnt, b);
			byte_cnt++;
		end
		if (fin) begin
			fold = {8'h00, run_sum[7:0]} + {8'h00, run_sum[23:16]} + rx_cksum;
			seq = {seq_bytes[7:0], seq_bytes[15:8], seq_bytes[23:16], seq_bytes[31:24]};
			v.good = !overrun && byte_cnt >= gbn_pkg::HEADER_BYTES + len_field &&
				len_field <= gbn_pkg::MAX_PAYLOAD && fold == gbn_pkg::CKSUM_OK;
			v.deliver = v.good && seq == next_seq;
			v.ack = v.good && seq <= next_seq;
			v.ack_num = seq_bytes;
			halves = {1'b0, seq_bytes[31:16]} + {1'b0, seq_bytes[15:0]};
			ack_fold = {8'h00, halves[7:0]} + {15'h0000, halves[16]};
			v.ack_ck = ~ack_fold;
			v.len = len_field[gbn_pkg::OUT_LEN_W-1:0];
			verdicts_due.push_back(v);
			if (v.deliver)
				next_seq++;
			clear_datagram();
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			clear_datagram();
			next_seq = '0;
			verdicts_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// compare before predicting so a stray result never meets a fresh verdict
			if (status.valid && status.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("status request with no datagram outstanding");
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					check_field("packet_good", want.good, status.packet_good);
					check_field("deliver", want.deliver, status.deliver);
					check_field("send_ack", want.ack, status.send_ack);
					check_field("ack_number", want.ack_num, status.ack_number);
					check_field("ack_checksum", want.ack_ck, status.ack_checksum);
					check_field("payload_length", want.len, status.payload_length);
				end
			end
			if (rx.valid && rx.ready)
				take_byte(rx.data_byte, rx.last_byte);
			pending = verdicts_due.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives datagrams into the go-back-N receiver: a directed set of edge cases
// (odd lengths, short, oversize, trailing, old and future sequence numbers),
// then mostly well-formed random datagrams mixed with corrupted and noise
// ones, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	gbn_rx_if     rx();
	gbn_status_if status();

	go_back_n_receiver_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.status (status)
	);

	datagram_verdict_monitor verdict_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	logic [7:0]  dgram[$];
	logic [31:0] tx_seq;     // sequence the receiver should deliver next
	bit          calm;       // no idling on either side while set
	int          ready_hold;
	int          bytes_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int stall_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
	endfunction

	// status side back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			status.ready <= 1'b0;
			ready_hold <= 0;
		end else if (calm) begin
			status.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			status.ready <= ($urandom_range(0, 9) < 7);
			ready_hold <= stall_len();
		end
	end

	// checksum over the header words and the payload up to the declared length
	function automatic void seal_checksum();
		logic [31:0] acc;
		logic [15:0] len;
		logic [15:0] fold;
		logic [15:0] ck;
		int          base;
		acc = '0;
		len = {dgram[gbn_pkg::IDX_LEN_HI], dgram[gbn_pkg::IDX_LEN_LO]};
		for (int i = 0; i < gbn_pkg::HEADER_BYTES; i += 2)
			if (i != gbn_pkg::IDX_CKSUM_HI)
				acc += {16'h0000, dgram[i], dgram[i+1]};
		for (int p = 0; p < len && gbn_pkg::HEADER_BYTES + p < dgram.size(); p += 2) begin
			base = gbn_pkg::HEADER_BYTES + p;
			if (p + 1 == len)
				acc += {24'h000000, dgram[base]};
			else if (base + 1 < dgram.size())
				acc += {16'h0000, dgram[base], dgram[base+1]};
		end
		fold = {8'h00, acc[7:0]} + {8'h00, acc[23:16]};
		ck = gbn_pkg::CKSUM_OK - fold;
		dgram[gbn_pkg::IDX_CKSUM_HI] = ck[15:8];
		dgram[gbn_pkg::IDX_CKSUM_LO] = ck[7:0];
	endfunction

	task automatic form_datagram(input logic [31:0] seq, input int len, input int plen);
		dgram.delete();
		for (int i = 0; i < gbn_pkg::SEQ_BYTES; i++)
			dgram.push_back(seq[8*i +: 8]);
		for (int i = gbn_pkg::SEQ_BYTES; i < gbn_pkg::IDX_CKSUM_HI; i++)
			dgram.push_back(8'($urandom));
		dgram.push_back(8'h00);
		dgram.push_back(8'h00);
		dgram.push_back(len[7:0]);
		dgram.push_back(len[15:8]);
		repeat (plen)
			dgram.push_back(8'($urandom));
		seal_checksum();
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		rx.valid <= 1'b1;
		rx.data_byte <= b;
		rx.last_byte <= fin;
		do @(posedge clk); while (!rx.ready);
		// idle gap so valid never drops and rises in one step
		if (!calm && $urandom_range(0, 3) == 0) begin
			rx.valid <= 1'b0;
			rx.data_byte <= 8'($urandom);
			rx.last_byte <= 1'($urandom);
			repeat (1 + stall_len()) @(posedge clk);
		end
	endtask

	task automatic send_datagram();
		foreach (dgram[i])
			send_byte(dgram[i], i == dgram.size() - 1);
		bytes_sent += dgram.size();
	endtask

	task automatic run_directed();
		// in-order deliveries: empty, odd single byte, odd length
		form_datagram(tx_seq, 0, 0);
		send_datagram();
		tx_seq++;
		form_datagram(tx_seq, 1, 1);
		send_datagram();
		tx_seq++;
		form_datagram(tx_seq, 7, 7);
		send_datagram();
		tx_seq++;
		// old sequence is acked only, future one neither
		form_datagram(0, 2, 2);
		send_datagram();
		form_datagram(32'hFFFF_FFFF, 3, 3);
		send_datagram();
		// corrupted checksum
		form_datagram(tx_seq, 4, 4);
		dgram[gbn_pkg::IDX_CKSUM_LO] ^= 8'h01;
		send_datagram();
		// short header, short payload, single byte
		form_datagram(tx_seq, 0, 0);
		dgram = dgram[0:9];
		send_datagram();
		form_datagram(tx_seq, 5, 5);
		dgram = dgram[0:dgram.size()-3];
		send_datagram();
		dgram.delete();
		dgram.push_back(8'hFF);
		send_datagram();
		// oversize length fields
		form_datagram(tx_seq, 'h0400, 0);
		send_datagram();
		form_datagram(tx_seq, 'hFFFF, 2);
		send_datagram();
		// trailing bytes beyond the declared length are ignored
		form_datagram(tx_seq, 2, 2);
		repeat (5)
			dgram.push_back(8'($urandom));
		send_datagram();
		tx_seq++;
		// all-ones filler drives carries into the upper sum byte
		form_datagram(tx_seq, 6, 6);
		for (int i = gbn_pkg::SEQ_BYTES; i < gbn_pkg::IDX_CKSUM_HI; i++)
			dgram[i] = 8'hFF;
		for (int i = gbn_pkg::HEADER_BYTES; i < dgram.size(); i++)
			dgram[i] = 8'hFF;
		seal_checksum();
		send_datagram();
		tx_seq++;
	endtask

	task automatic run_random();
		int kind;
		int plen;
		int cut;
		int pos;
		while (bytes_sent < 450) begin
			if ($urandom_range(0, 7) == 0)
				calm <= ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 99);
			plen = pick_len();
			if (kind < 55) begin
				form_datagram(tx_seq, plen, plen);
				tx_seq++;
			end else if (kind < 70) begin
				form_datagram(tx_seq - $urandom_range(1, 6), plen, plen);
			end else if (kind < 78) begin
				form_datagram(tx_seq + $urandom_range(1, 1000), plen, plen);
			end else if (kind < 86) begin
				// damaged content or oversize length, never the next sequence
				form_datagram(tx_seq + $urandom_range(1, 100), plen, plen);
				if ($urandom_range(0, 1)) begin
					pos = $urandom_range(gbn_pkg::SEQ_BYTES, dgram.size() - 1);
					dgram[pos] ^= 8'(1 << $urandom_range(0, 7));
				end else begin
					dgram[gbn_pkg::IDX_LEN_HI] = 8'($urandom_range(4, 255));
				end
			end else if (kind < 93) begin
				form_datagram(tx_seq, plen, plen);
				cut = $urandom_range(1, dgram.size() - 1);
				dgram = dgram[0:dgram.size()-1-cut];
			end else if (kind < 97) begin
				form_datagram(tx_seq, plen, plen);
				repeat ($urandom_range(1, 8))
					dgram.push_back(8'($urandom));
				tx_seq++;
			end else begin
				dgram.delete();
				repeat ($urandom_range(1, 40))
					dgram.push_back(8'($urandom));
			end
			send_datagram();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.data_byte = 8'h00;
		rx.last_byte = 1'b0;
		calm = 1'b0;
		tx_seq = '0;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		rx.valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
